// ----- rtl/wpd_pkg.sv -----
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types and constants of the word packet deframer.
// ----------------------------------------------------------------------------
package wpd_pkg;

    // Deframing phase
    typedef enum logic [2:0] {
        PH_WAIT_HEAD,
        PH_WANT_SIZE,
        PH_WANT_START,
        PH_WANT_FIRST,
        PH_DATA,
        PH_WANT_SUM
    } phase_t;

    // Result status codes
    localparam logic [1:0] ST_GOOD     = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEAD_SIGN  = 2'd0;
    localparam logic [1:0] CFG_START_SIGN = 2'd1;
    localparam logic [1:0] CFG_END_SIGN   = 2'd2;

    // Configuration reset values
    localparam logic [31:0] HEAD_SIGN_RST  = 32'd1;
    localparam logic [31:0] START_SIGN_RST = 32'd2;
    localparam logic [31:0] END_SIGN_RST   = 32'd3;

    // Checksum outcome, control to replay
    typedef struct packed {
        logic       replay;
        logic       status_only;
        logic [1:0] status;
    } res_req_t;

    // Replay status, replay to control
    typedef struct packed {
        logic busy;
        logic slot_free;
    } rep_stat_t;

endpackage

// ----- rtl/word_packet_deframer_sum_check_core.sv -----
// ----------------------------------------------------------------------------
// word_packet_deframer_sum_check_core
// Word packet deframer with a 32-bit wrapping checksum and in-order replay.
//
// Takes one word a beat, one beat per clock while a packet is being
// deframed (head sign, size, start sign, data, end sign, checksum). Data
// words are written to a BUF_WORDS-deep RAM; words past its end are summed
// but dropped and flag overflow. The checksum beat waits only while the
// output register holds a result not yet taken. A good packet is replayed
// from the RAM in order, one registered read in flight at a time; input
// is held off until the last stored word has been read into the output
// register. A mismatch or overflow gives a single status beat. No
// clearing pass after reset: only written entries are read.
// ----------------------------------------------------------------------------
module word_packet_deframer_sum_check_core #(
    parameter int BUF_WORDS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] word,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [31:0] data_word,
    output logic [31:0] byte_size,
    output logic [1:0]  status,
    output logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int AW = (BUF_WORDS > 1) ? $clog2(BUF_WORDS) : 1;
    localparam int CW = $clog2(BUF_WORDS + 1);

    // sign registers
    logic [31:0] head_sign_reg;
    logic [31:0] start_sign_reg;
    logic [31:0] end_sign_reg;

    wpd_pkg::res_req_t  req;
    wpd_pkg::rep_stat_t rstat;
    logic [CW-1:0]      stored_count;
    logic [31:0]        declared_size;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;

    // config writes; an index past the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_sign_reg  <= wpd_pkg::HEAD_SIGN_RST;
            start_sign_reg <= wpd_pkg::START_SIGN_RST;
            end_sign_reg   <= wpd_pkg::END_SIGN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                wpd_pkg::CFG_HEAD_SIGN:  head_sign_reg  <= cfg_wdata;
                wpd_pkg::CFG_START_SIGN: start_sign_reg <= cfg_wdata;
                wpd_pkg::CFG_END_SIGN:   end_sign_reg   <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // phase, sum and store fill
    wpd_ctrl #(
        .BUF_WORDS (BUF_WORDS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .word          (word),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .head_sign     (head_sign_reg),
        .start_sign    (start_sign_reg),
        .end_sign      (end_sign_reg),
        .rstat         (rstat),
        .req           (req),
        .stored_count  (stored_count),
        .declared_size (declared_size),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata)
    );

    // payload store
    wpd_ram #(
        .WIDTH (32),
        .DEPTH (BUF_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // replay sequencer and output register
    wpd_replay #(
        .BUF_WORDS (BUF_WORDS)
    ) u_replay (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .stored_count  (stored_count),
        .declared_size (declared_size),
        .rstat         (rstat),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .data_word     (data_word),
        .byte_size     (byte_size),
        .status        (status),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready)
    );

endmodule

// ----- rtl/wpd_ram.sv -----
// ----------------------------------------------------------------------------
// wpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/wpd_ctrl.sv -----
// ----------------------------------------------------------------------------
// wpd_ctrl
// Phase tracking, running sum and store fill; raises the checksum outcome.
// ----------------------------------------------------------------------------
module wpd_ctrl #(
    parameter int BUF_WORDS = 32,
    localparam int AW = (BUF_WORDS > 1) ? $clog2(BUF_WORDS) : 1,
    localparam int CW = $clog2(BUF_WORDS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        word,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        head_sign,
    input  logic [31:0]        start_sign,
    input  logic [31:0]        end_sign,
    input  wpd_pkg::rep_stat_t rstat,
    output wpd_pkg::res_req_t  req,
    output logic [CW-1:0]      stored_count,
    output logic [31:0]        declared_size,
    output logic               ram_we,
    output logic [AW-1:0]      ram_waddr,
    output logic [31:0]        ram_wdata
);

    wpd_pkg::phase_t phase_reg, phase_next;
    logic [31:0]     size_reg, size_next;
    logic [31:0]     sum_reg, sum_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic            accept;
    logic            take;
    logic [CW-1:0]   base_count;
    logic [31:0]     base_sum;
    logic            base_ovf;

    // checksum beat needs the output slot; replay holds input off
    assign in_ready = !rstat.busy &&
                      ((phase_reg != wpd_pkg::PH_WANT_SUM) || rstat.slot_free);
    assign accept   = in_valid && in_ready;

    assign stored_count  = count_reg;
    assign declared_size = size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= wpd_pkg::PH_WAIT_HEAD;
            size_reg  <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            size_reg  <= size_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                wpd_pkg::PH_WAIT_HEAD:
                begin
                    if (word == head_sign)
                    begin
                        phase_next = wpd_pkg::PH_WANT_SIZE;
                    end
                end
                wpd_pkg::PH_WANT_SIZE:
                begin
                    phase_next = wpd_pkg::PH_WANT_START;
                end
                wpd_pkg::PH_WANT_START:
                begin
                    if (word == start_sign)
                    begin
                        phase_next = wpd_pkg::PH_WANT_FIRST;
                    end
                end
                wpd_pkg::PH_WANT_FIRST:
                begin
                    if (word != end_sign)
                    begin
                        phase_next = wpd_pkg::PH_DATA;
                    end
                end
                wpd_pkg::PH_DATA:
                begin
                    if (word == end_sign)
                    begin
                        phase_next = wpd_pkg::PH_WANT_SUM;
                    end
                end
                wpd_pkg::PH_WANT_SUM:
                begin
                    phase_next = wpd_pkg::PH_WAIT_HEAD;
                end
                default:
                begin
                    phase_next = wpd_pkg::PH_WAIT_HEAD;
                end
            endcase
        end
    end

    // datapath and outputs
    always_comb
    begin
        size_next  = size_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        req        = '0;
        take       = 1'b0;
        base_count = count_reg;
        base_sum   = sum_reg;
        base_ovf   = ovf_reg;
        ram_we     = 1'b0;
        ram_waddr  = count_reg[AW-1:0];
        ram_wdata  = word;

        if (accept)
        begin
            unique case (phase_reg)
                wpd_pkg::PH_WANT_SIZE:
                begin
                    size_next = word;
                end
                wpd_pkg::PH_WANT_FIRST:
                begin
                    if (word != end_sign)
                    begin
                        // fresh packet body
                        base_count = '0;
                        base_sum   = '0;
                        base_ovf   = 1'b0;
                        take       = 1'b1;
                    end
                end
                wpd_pkg::PH_DATA:
                begin
                    take = (word != end_sign);
                end
                wpd_pkg::PH_WANT_SUM:
                begin
                    if (word != sum_reg)
                    begin
                        req.status_only = 1'b1;
                        req.status      = wpd_pkg::ST_MISMATCH;
                    end
                    else if (ovf_reg)
                    begin
                        req.status_only = 1'b1;
                        req.status      = wpd_pkg::ST_OVERFLOW;
                    end
                    else if (count_reg == '0)
                    begin
                        req.status_only = 1'b1;
                        req.status      = wpd_pkg::ST_GOOD;
                    end
                    else
                    begin
                        req.replay = 1'b1;
                        req.status = wpd_pkg::ST_GOOD;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (take)
        begin
            sum_next   = base_sum + word;
            count_next = base_count;
            ovf_next   = base_ovf;
            if (base_count < CW'(BUF_WORDS))
            begin
                ram_we     = 1'b1;
                ram_waddr  = base_count[AW-1:0];
                count_next = base_count + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

endmodule

// ----- rtl/wpd_replay.sv -----
// ----------------------------------------------------------------------------
// wpd_replay
// Reads the store back in order and holds the output register.
// ----------------------------------------------------------------------------
module wpd_replay #(
    parameter int BUF_WORDS = 32,
    localparam int AW = (BUF_WORDS > 1) ? $clog2(BUF_WORDS) : 1,
    localparam int CW = $clog2(BUF_WORDS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  wpd_pkg::res_req_t  req,
    input  logic [CW-1:0]      stored_count,
    input  logic [31:0]        declared_size,
    output wpd_pkg::rep_stat_t rstat,
    output logic               ram_re,
    output logic [AW-1:0]      ram_raddr,
    input  logic [31:0]        ram_rdata,
    output logic [31:0]        data_word,
    output logic [31:0]        byte_size,
    output logic [1:0]         status,
    output logic               last,
    output logic               out_valid,
    input  logic               out_ready
);

    logic          act_reg;
    logic          pend_reg;
    logic          pend_last_reg;
    logic [CW-1:0] rd_cnt_reg;
    logic          out_valid_reg;
    logic [31:0]   out_data_reg;
    logic [31:0]   out_size_reg;
    logic [1:0]    out_status_reg;
    logic          out_last_reg;
    logic          slot_free;
    logic          issue;
    logic [CW-1:0] rd_cnt_inc;
    logic          issue_last;

    assign slot_free  = !out_valid_reg || out_ready;
    // one read in flight; it lands in a slot that is free by then
    assign issue      = act_reg && !pend_reg && slot_free;
    assign rd_cnt_inc = rd_cnt_reg + 1'b1;
    assign issue_last = (rd_cnt_inc == stored_count);

    assign ram_re    = issue;
    assign ram_raddr = rd_cnt_reg[AW-1:0];

    assign rstat.busy      = act_reg || pend_reg;
    assign rstat.slot_free = slot_free;

    assign data_word = out_data_reg;
    assign byte_size = out_size_reg;
    assign status    = out_status_reg;
    assign last      = out_last_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.replay)
            begin
                act_reg    <= 1'b1;
                rd_cnt_reg <= '0;
            end
            else if (issue)
            begin
                rd_cnt_reg    <= rd_cnt_inc;
                pend_last_reg <= issue_last;
                if (issue_last)
                begin
                    act_reg <= 1'b0;
                end
            end
            pend_reg <= issue;

            if (pend_reg || req.status_only)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            out_data_reg   <= ram_rdata;
            out_size_reg   <= declared_size;
            out_status_reg <= wpd_pkg::ST_GOOD;
            out_last_reg   <= pend_last_reg;
        end
        else if (req.status_only)
        begin
            out_data_reg   <= '0;
            out_size_reg   <= declared_size;
            out_status_reg <= req.status;
            out_last_reg   <= 1'b1;
        end
    end

endmodule

// ----- rtl/wpd_chk.sv -----
// ----------------------------------------------------------------------------
// wpd_chk
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module wpd_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic [31:0] data_word,
    input logic [31:0] byte_size,
    input logic [1:0]  status,
    input logic        last,
    input logic        out_valid,
    input logic        out_ready
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_word) &&
        $stable(byte_size) && $stable(status) && $stable(last))
        else $error("output beat changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == wpd_pkg::ST_GOOD) ||
        (status == wpd_pkg::ST_MISMATCH) || (status == wpd_pkg::ST_OVERFLOW))
        else $error("undefined status code");

    // error results are single, empty beats
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != wpd_pkg::ST_GOOD) |-> last && (data_word == '0))
        else $error("error result not a single empty beat");

    // mid-replay the input stays closed
    a_replay_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input open during replay");

endmodule

bind word_packet_deframer_sum_check_core wpd_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .data_word (data_word),
    .byte_size (byte_size),
    .status    (status),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready)
);

// ----- test/word_packet_deframer_sum_check_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_packet_deframer_sum_check_core_tb
// Self-checking bench for the word packet deframer with checksum.
//
// A short table of hand-picked words runs against the reset signs first. Then
// five sign settings follow, each with a stream of mostly well-formed random
// packets, some noise and some broken frames. A bench-side deframer works out
// every result beat, and each beat leaving the block is compared with the
// oldest one still due. The sender works in bursts. The receiver stalls on
// its own pattern, and once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module word_packet_deframer_sum_check_core_tb;

    localparam int BUF_WORDS   = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 8;     // slack after the last owed beat
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int PHASE_WORDS = 46;    // framed words per sign setting

    typedef struct packed {
        logic [31:0] data_word;
        logic [31:0] byte_size;
        logic [1:0]  status;
        logic        last;
    } beat_t;

    // One directed row: a word, how often it is sent, and, for status-only
    // outcomes, the beat typed in by hand.
    typedef struct packed {
        logic [31:0] w;
        logic [7:0]  reps;
        logic        typed;
        logic [1:0]  st;
        logic [31:0] sz;
    } stim_row_t;

    localparam int N_ROWS = 29;

    logic        clk;
    logic        rst_n;
    logic [31:0] word;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] data_word;
    logic [31:0] byte_size;
    logic [1:0]  status;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    word_packet_deframer_sum_check_core #(
        .BUF_WORDS (BUF_WORDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .word      (word),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_word (data_word),
        .byte_size (byte_size),
        .status    (status),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Bench-side deframer: signs, phase, sum and payload copy
    // ------------------------------------------------------------------------
    logic [31:0] head_sign_r;
    logic [31:0] start_sign_r;
    logic [31:0] end_sign_r;

    wpd_pkg::phase_t dfr_phase;
    logic [31:0] pkt_size;
    logic [31:0] pkt_sum;
    int          pkt_count;
    logic        pkt_ovf;
    logic [31:0] pay_copy [BUF_WORDS];

    beat_t       new_beats[$];   // beats caused by the word just taken
    beat_t       due_beats[$];   // beats still owed by the block

    int          errors;
    int          kept_words;     // words that moved the framing along
    bit          offering;       // sender currently holds valid high
    int          burst_left;
    bit          hold_req;

    function automatic beat_t status_beat(input logic [1:0] st);
        beat_t b;
        b.data_word = 32'd0;
        b.byte_size = pkt_size;
        b.status    = st;
        b.last      = 1'b1;
        return b;
    endfunction

    // Sum every data word; keep it only while there is room.
    task automatic absorb_data(input logic [31:0] w);
        pkt_sum = pkt_sum + w;
        if (pkt_count < BUF_WORDS)
        begin
            pay_copy[pkt_count] = w;
            pkt_count++;
        end
        else
            pkt_ovf = 1'b1;
    endtask

    task automatic deframe_word(input logic [31:0] w, output bit kept);
        beat_t b;
        new_beats.delete();
        kept = 1'b1;
        unique case (dfr_phase)
            wpd_pkg::PH_WAIT_HEAD:
                if (w == head_sign_r)
                    dfr_phase = wpd_pkg::PH_WANT_SIZE;
                else
                    kept = 1'b0;
            wpd_pkg::PH_WANT_SIZE:
            begin
                pkt_size  = w;
                dfr_phase = wpd_pkg::PH_WANT_START;
            end
            wpd_pkg::PH_WANT_START:
                if (w == start_sign_r)
                    dfr_phase = wpd_pkg::PH_WANT_FIRST;
                else
                    kept = 1'b0;
            wpd_pkg::PH_WANT_FIRST:
                if (w != end_sign_r)
                begin
                    pkt_sum   = 32'd0;
                    pkt_count = 0;
                    pkt_ovf   = 1'b0;
                    absorb_data(w);
                    dfr_phase = wpd_pkg::PH_DATA;
                end
                else
                    kept = 1'b0;
            wpd_pkg::PH_DATA:
                if (w == end_sign_r)
                    dfr_phase = wpd_pkg::PH_WANT_SUM;
                else
                    absorb_data(w);
            wpd_pkg::PH_WANT_SUM:
            begin
                dfr_phase = wpd_pkg::PH_WAIT_HEAD;
                // mismatch wins over overflow
                if (w != pkt_sum)
                    new_beats.push_back(status_beat(wpd_pkg::ST_MISMATCH));
                else if (pkt_ovf)
                    new_beats.push_back(status_beat(wpd_pkg::ST_OVERFLOW));
                else if (pkt_count == 0)
                    new_beats.push_back(status_beat(wpd_pkg::ST_GOOD));
                else
                    for (int i = 0; i < pkt_count; i++)
                    begin
                        b.data_word = pay_copy[i];
                        b.byte_size = pkt_size;
                        b.status    = wpd_pkg::ST_GOOD;
                        b.last      = (i == pkt_count - 1);
                        new_beats.push_back(b);
                    end
            end
            default:
                dfr_phase = wpd_pkg::PH_WAIT_HEAD;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Sender: bursts of beats with idle gaps in between
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [31:0] w, input bit typed, input beat_t typed_beat);
        int gap;
        bit kept;
        if (!offering)
        begin
            // the gap is never empty, since valid may have dropped this step
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 16);
            offering = 1'b1;
        end
        word     <= w;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        deframe_word(w, kept);
        if (kept)
            kept_words++;
        if (typed)
            due_beats.push_back(typed_beat);
        else
            foreach (new_beats[i])
                due_beats.push_back(new_beats[i]);
        burst_left--;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic send_plain(input logic [31:0] w);
        send_word(w, 1'b0, '0);
    endtask

    // Drop valid, let every owed beat come out, then let the block idle.
    task automatic drain_block();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        while (due_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic program_signs(input logic [31:0] h, input logic [31:0] s,
                                 input logic [31:0] e);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= wpd_pkg::CFG_HEAD_SIGN;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_index <= wpd_pkg::CFG_START_SIGN;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_index <= wpd_pkg::CFG_END_SIGN;
        cfg_wdata <= e;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        head_sign_r  = h;
        start_sign_r = s;
        end_sign_r   = e;
    endtask

    // One packet with random content; now and then noise in front, a wrong
    // start sign, an early end sign, a truncated frame or a bad checksum.
    task automatic send_packet();
        int          n;
        int          pick;
        logic [31:0] v;
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) send_plain($urandom);
        pick = $urandom_range(0, 19);
        if (pick < 14)
            n = $urandom_range(1, 8);
        else if (pick < 16)
            n = $urandom_range(9, 31);
        else if (pick < 18)
            n = BUF_WORDS;
        else
            n = $urandom_range(BUF_WORDS + 1, BUF_WORDS + 8);
        send_plain(head_sign_r);
        send_plain(($urandom_range(0, 3) == 0) ? $urandom : 32'(n * 4));
        if ($urandom_range(0, 11) == 0)
            return;     // truncated: next head falls on the start-sign wait
        if ($urandom_range(0, 7) == 0)
        begin
            v = $urandom;
            send_plain((v == start_sign_r) ? ~v : v);
        end
        send_plain(start_sign_r);
        if ($urandom_range(0, 9) == 0)
            send_plain(end_sign_r);
        for (int k = 0; k < n; k++)
        begin
            v = $urandom;
            send_plain((v == end_sign_r) ? ~v : v);
        end
        send_plain(end_sign_r);
        v = pkt_sum;
        if ($urandom_range(0, 4) == 0)
            v = v ^ (32'd1 << $urandom_range(0, 31));
        send_plain(v);
    endtask

    // ------------------------------------------------------------------------
    // Result checking against the oldest owed beat
    // ------------------------------------------------------------------------
    task automatic check_beat();
        beat_t want;
        if (due_beats.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected beat, exp none, got data %h size %h status %0d last %b",
                     $time, data_word, byte_size, status, last);
        end
        else
        begin
            want = due_beats.pop_front();
            if (data_word !== want.data_word)
            begin
                errors++;
                $display("%0t: data_word exp %h got %h", $time, want.data_word, data_word);
            end
            if (byte_size !== want.byte_size)
            begin
                errors++;
                $display("%0t: byte_size exp %h got %h", $time, want.byte_size, byte_size);
            end
            if (status !== want.status)
            begin
                errors++;
                $display("%0t: status exp %0d got %0d", $time, want.status, status);
            end
            if (last !== want.last)
            begin
                errors++;
                $display("%0t: last exp %b got %b", $time, want.last, last);
            end
        end
    endtask

    // Values read here are the ones before the edge: everything on both
    // sides changes through nonblocking updates.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_beat();
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int mode;
        int span;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                @(posedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            for (int k = 0; k < span; k++)
            begin
                @(posedge clk);
                unique case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ((k % 4) == 3);
                    default: out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: timeout", $time);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Directed table, run against the reset signs (head 1, start 2, end 3).
    // Only status-only outcomes carry a hand-typed beat; replays go through
    // the bench-side deframer.
    // ------------------------------------------------------------------------
    stim_row_t dir_rows [N_ROWS] = '{
        '{32'h0000_0000, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},   // noise while waiting
        '{32'hFFFF_FFFF, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},   // noise while waiting
        '{32'h0000_0001, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},   // head
        '{32'hFFFF_FFFF, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},   // largest size
        '{32'h0000_0007, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},   // wrong start sign
        '{32'h0000_0002, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},   // start
        '{32'h0000_0003, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},   // end sign before data
        '{32'hFFFF_FFFF, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},   // data, all ones
        '{32'h0000_0001, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},   // data equal to head
        '{32'h0000_0003, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},   // end
        '{32'h0000_0000, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},   // sum wraps to zero
        '{32'h0000_0001, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},
        '{32'h0000_0000, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},   // size zero
        '{32'h0000_0002, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},
        '{32'h1234_5678, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},
        '{32'h0000_0003, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},
        '{32'h1234_5679, 8'd1,  1'b1, wpd_pkg::ST_MISMATCH, 32'd0},   // checksum off by one
        '{32'h0000_0001, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},
        '{32'h0000_0080, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},
        '{32'h0000_0002, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},
        '{32'h0000_0002, 8'd33, 1'b0, wpd_pkg::ST_GOOD,     32'd0},   // one past the buffer
        '{32'h0000_0003, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},
        '{32'h0000_0042, 8'd1,  1'b1, wpd_pkg::ST_OVERFLOW, 32'h80},  // sum ok, overflowed
        '{32'h0000_0001, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},
        '{32'h0000_0004, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},
        '{32'h0000_0002, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},
        '{32'h5A5A_A5A5, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},
        '{32'h0000_0003, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0},
        '{32'h5A5A_A5A5, 8'd1,  1'b0, wpd_pkg::ST_GOOD,     32'd0}    // single-word replay
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        beat_t typed_beat;
        int    goal;

        rst_n     = 1'b0;
        word      = 32'd0;
        in_valid  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = wpd_pkg::CFG_HEAD_SIGN;
        cfg_wdata = 32'd0;

        head_sign_r  = wpd_pkg::HEAD_SIGN_RST;
        start_sign_r = wpd_pkg::START_SIGN_RST;
        end_sign_r   = wpd_pkg::END_SIGN_RST;
        dfr_phase    = wpd_pkg::PH_WAIT_HEAD;
        pkt_size     = 32'd0;
        pkt_sum      = 32'd0;
        pkt_count    = 0;
        pkt_ovf      = 1'b0;
        errors       = 0;
        kept_words   = 0;
        offering     = 1'b0;
        burst_left   = 0;
        hold_req     = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            typed_beat.data_word = 32'd0;
            typed_beat.byte_size = dir_rows[r].sz;
            typed_beat.status    = dir_rows[r].st;
            typed_beat.last      = 1'b1;
            repeat (dir_rows[r].reps)
                send_word(dir_rows[r].w, dir_rows[r].typed, typed_beat);
        end

        // Random packets under five sign settings, extremes first
        for (int ph = 0; ph < 5; ph++)
        begin
            drain_block();
            unique case (ph)
                0: program_signs(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
                1: program_signs(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
                2: program_signs($urandom, $urandom, $urandom);
                3:
                begin
                    // one value for all three signs
                    goal = $urandom;
                    program_signs(goal, goal, goal);
                end
                default: program_signs($urandom, $urandom, $urandom);
            endcase
            if (ph == 2)
                hold_req = 1'b1;   // receiver backs off while packets keep coming
            goal = kept_words + PHASE_WORDS;
            while (kept_words < goal)
                send_packet();
        end

        drain_block();
        repeat (SETTLE) @(posedge clk);

        if (errors == 0 && due_beats.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
